// ===== hdl/dcm_pkg.sv =====
// Package: shared types, constants and state codes of the duty cycle meter.
`timescale 1ns / 1ps

package dcm_pkg;

  localparam int TIME_W = 32;
  localparam int DUTY_W = 10;

  // Duty full scale: 1000 tenths of a percent.
  localparam int DUTY_FULL_INT = 1000;
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(DUTY_FULL_INT);

  // Numerator on_time * 1000 fits in 42 bits; one more bit for the shifted divisor.
  localparam int NUM_W = TIME_W + DUTY_W + 1;

  // Quotient bits worked out by the divider (values up to 2047).
  localparam int QBITS = 11;
  localparam int CNT_W = $clog2(QBITS);

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] window;
  } dcm_job_t;

  localparam int JOB_W = $bits(dcm_job_t);

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_CHK,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ===== hdl/dcm_fifo.sv =====
// Small register queue between the front and the back of the duty cycle meter.
`timescale 1ns / 1ps

module dcm_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dcm_front.sv =====
// Front end: takes edges always, tracks pin level and on time, queues reports.
`timescale 1ns / 1ps

module dcm_front import dcm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic              level,
  input  logic [TIME_W-1:0] now_us,
  output logic              job_valid,
  input  logic              job_ready,
  output dcm_job_t          job
);

  logic              held_level;
  logic [TIME_W-1:0] last_edge_time;
  logic [TIME_W-1:0] high_accum;
  logic [TIME_W-1:0] window_start;

  logic [TIME_W-1:0] high_time;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat_sum;
  logic              accept;

  // Edges never wait; a report waits only for room in the queue.
  assign in_ready  = (op == OP_EDGE) || job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = in_valid && (op == OP_REPORT);

  // Open high interval closed with a saturating add.
  assign high_time = now_us - last_edge_time;
  assign sum       = {1'b0, high_accum} + {1'b0, high_time};
  assign sat_sum   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  assign job.on_time = held_level ? sat_sum : high_accum;
  assign job.window  = now_us - window_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_level     <= 1'b0;
      last_edge_time <= '0;
      high_accum     <= '0;
      window_start   <= '0;
    end else if (accept) begin
      if (op == OP_REPORT) begin
        high_accum     <= '0;
        last_edge_time <= now_us;
        window_start   <= now_us;
      end else if (level != held_level) begin
        held_level     <= level;
        last_edge_time <= now_us;
        if (!level) begin
          high_accum <= sat_sum;
        end
      end
    end
  end

endmodule

// ===== hdl/dcm_back.sv =====
// Back end: restoring divider for the duty ratio and the result output register.
`timescale 1ns / 1ps

module dcm_back import dcm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  dcm_job_t          job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUTY_W-1:0] duty_tenths,
  output logic [TIME_W-1:0] on_time_us,
  output logic [TIME_W-1:0] window_us,
  output logic              empty_window
);

  back_state_t state, state_next;

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] divisor;
  logic [QBITS-1:0] quot;
  logic [CNT_W-1:0] cnt;

  logic [NUM_W-1:0] div_full;
  logic [NUM_W-1:0] rem_sub;
  logic             take;
  logic [QBITS-1:0] quot_step;
  logic             sat_hit;

  assign div_full  = {window_us, QBITS'(0)};
  assign sat_hit   = (rem >= div_full);
  assign take      = (rem >= divisor);
  assign rem_sub   = rem - divisor;
  assign quot_step = {quot[QBITS-2:0], take};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (job_valid) state_next = B_MUL;
      B_MUL:  state_next = B_CHK;
      B_CHK: begin
        if (window_us == '0 || sat_hit) begin
          state_next = B_OUT;
        end else begin
          state_next = B_DIV;
        end
      end
      B_DIV:  if (cnt == '0) state_next = B_OUT;
      B_OUT:  if (out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    job_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      B_IDLE:  job_ready = 1'b1;
      B_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        on_time_us   <= job.on_time;
        window_us    <= job.window;
        empty_window <= 1'b0;
      end
      B_MUL: begin
        // Full 42-bit product of on time and full scale.
        rem <= NUM_W'(on_time_us) * NUM_W'(DUTY_FULL_INT);
      end
      B_CHK: begin
        divisor <= {1'b0, window_us, (QBITS-1)'(0)};
        quot    <= '0;
        cnt     <= CNT_W'(QBITS - 1);
        if (window_us == '0) begin
          empty_window <= 1'b1;
          duty_tenths  <= '0;
        end else if (sat_hit) begin
          duty_tenths <= DUTY_FULL;
        end
      end
      B_DIV: begin
        if (take) begin
          rem <= rem_sub;
        end
        quot    <= quot_step;
        divisor <= divisor >> 1;
        cnt     <= cnt - 1'b1;
        if (cnt == '0) begin
          duty_tenths <= (quot_step > QBITS'(DUTY_FULL_INT)) ? DUTY_FULL
                                                             : quot_step[DUTY_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/duty_cycle_meter_unit.sv =====
// Top level of the duty cycle meter: front end, job queue and divider back end.
`timescale 1ns / 1ps

// Duty cycle meter. Each input beat is either a pin edge event (op = 0, with
// level and now_us) or a report request (op = 1, with now_us). Edge events
// are absorbed by the front end at one beat per clock and never produce a
// result; an edge whose level matches the held level is dropped. Falling
// edges add the high time to a saturating 32-bit on-time accumulator. A
// report closes any open high interval, captures on time and window length,
// restarts the window at now_us and queues a job; the report beat itself
// is accepted as long as the job queue (QUEUE_DEPTH entries) has room.
// The back end turns each job into one result beat: duty_tenths =
// floor(on_time * 1000 / window), capped at 1000, with empty_window set and
// duty 0 for a zero-length window. The back end runs a multiply, a range
// check and then, unless the window is empty or saturated, an 11-step
// restoring divider at one quotient bit per cycle, and holds the result
// beat in the output register until it is taken. It takes a new job only
// after that, so further reports wait in the queue and stall once it is
// full; edge beats keep flowing at one per cycle regardless. All timestamp
// differences wrap modulo 2^32. After reset the pin is taken as low and all
// timestamps start at zero.
module duty_cycle_meter_unit import dcm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic              level,
  input  logic [TIME_W-1:0] now_us,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUTY_W-1:0] duty_tenths,
  output logic [TIME_W-1:0] on_time_us,
  output logic [TIME_W-1:0] window_us,
  output logic              empty_window
);

  dcm_job_t          push_job;
  logic              push_valid;
  logic              push_ready;
  logic [JOB_W-1:0]  pop_data;
  logic              pop_valid;
  logic              pop_ready;

  // Front end: level tracking, accumulator and report capture.
  dcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .level     (level),
    .now_us    (now_us),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  // Report jobs wait here while the divider is busy.
  dcm_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: duty ratio divider and result register.
  dcm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (pop_valid),
    .job_ready    (pop_ready),
    .job          (dcm_job_t'(pop_data)),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .duty_tenths  (duty_tenths),
    .on_time_us   (on_time_us),
    .window_us    (window_us),
    .empty_window (empty_window)
  );

endmodule
